// ===== rtl/tmk_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmk_pkg
// shared types, character codes and the morse element rom of the keyer
// ----------------------------------------------------------------------------
package tmk_pkg;

    // configuration port
    localparam int CFG_AW = 4;

    localparam logic [1:0] REG_START_SPEED = 2'd0;
    localparam logic [1:0] REG_MIN_SPEED   = 2'd1;
    localparam logic [1:0] REG_MAX_SPEED   = 2'd2;

    // character codes
    localparam logic [7:0] C_SPACE     = 8'h20;
    localparam logic [7:0] C_CH_FIRST  = 8'h21;
    localparam logic [7:0] C_CH_LAST   = 8'h5a;
    localparam logic [7:0] C_AMP       = 8'h26;
    localparam logic [7:0] C_CMD_FIRST = 8'h5d;
    localparam logic [7:0] C_CMD_LAST  = 8'h7f;
    localparam logic [7:0] C_CMD_A     = 8'h61;
    localparam logic [7:0] C_CMD_B     = 8'h62;
    localparam logic [7:0] C_CMD_Z     = 8'h7a;
    localparam logic [7:0] C_CMD_U     = 8'h75;
    localparam logic [7:0] C_CMD_L     = 8'h6c;
    localparam logic [7:0] C_CMD_M     = 8'h6d;
    localparam logic [7:0] C_CMD_H     = 8'h68;

    // power levels
    localparam logic [1:0] PWR_ULTRA_LOW = 2'd0;
    localparam logic [1:0] PWR_LOW       = 2'd1;
    localparam logic [1:0] PWR_MEDIUM    = 2'd2;
    localparam logic [1:0] PWR_HIGH      = 2'd3;

    // element lengths in dits
    localparam logic [4:0] DIT_LEN = 5'd1;
    localparam logic [4:0] DAH_LEN = 5'd3;

    localparam logic KIND_KEY   = 1'b0;
    localparam logic KIND_POWER = 1'b1;
    localparam logic UNIT_DITS  = 1'b0;
    localparam logic UNIT_SECS  = 1'b1;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_A      = 3'd1,
        MODE_B      = 3'd2,
        MODE_Z1     = 3'd3,
        MODE_Z2     = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AMP_ON,
        S_AMP_GAP,
        S_ON,
        S_OFF,
        S_TIMED,
        S_TAIL
    } t_state;

    typedef struct packed {
        logic [6:0] start_speed_wpm;
        logic [6:0] min_speed_wpm;
        logic [6:0] max_speed_wpm;
    } t_cfg;

    // segment without the status fields
    typedef struct packed {
        logic       kind;
        logic       key_on;
        logic [4:0] duration;
        logic       time_unit;
    } t_core;

    typedef struct packed {
        t_core      core;
        logic [1:0] power_level;
        logic [7:0] speed_wpm;
        logic       last;
    } t_seg;

    typedef struct packed {
        logic [7:0] bits;
        logic [2:0] count;
    } t_elem;

    // element rom for '!' .. 'Z', bits lsb first, 1 = dit
    function automatic t_elem elem_rom(input logic [5:0] idx);
        t_elem e;
        e = '{bits: 8'h00, count: 3'd0};
        unique case (idx)
            6'd0:    e = '{bits: 8'h0a, count: 3'd6};
            6'd1:    e = '{bits: 8'h2d, count: 3'd6};
            6'd3:    e = '{bits: 8'h37, count: 3'd7};
            6'd5:    e = '{bits: 8'h07, count: 3'd3};
            6'd6:    e = '{bits: 8'h21, count: 3'd6};
            6'd7:    e = '{bits: 8'h12, count: 3'd5};
            6'd8:    e = '{bits: 8'h12, count: 3'd6};
            6'd10:   e = '{bits: 8'h15, count: 3'd5};
            6'd11:   e = '{bits: 8'h0c, count: 3'd6};
            6'd12:   e = '{bits: 8'h1e, count: 3'd6};
            6'd13:   e = '{bits: 8'h15, count: 3'd6};
            6'd14:   e = '{bits: 8'h16, count: 3'd5};
            6'd15:   e = '{bits: 8'h00, count: 3'd5};
            6'd16:   e = '{bits: 8'h01, count: 3'd5};
            6'd17:   e = '{bits: 8'h03, count: 3'd5};
            6'd18:   e = '{bits: 8'h07, count: 3'd5};
            6'd19:   e = '{bits: 8'h0f, count: 3'd5};
            6'd20:   e = '{bits: 8'h1f, count: 3'd5};
            6'd21:   e = '{bits: 8'h1e, count: 3'd5};
            6'd22:   e = '{bits: 8'h1c, count: 3'd5};
            6'd23:   e = '{bits: 8'h18, count: 3'd5};
            6'd24:   e = '{bits: 8'h10, count: 3'd5};
            6'd25:   e = '{bits: 8'h38, count: 3'd6};
            6'd26:   e = '{bits: 8'h2a, count: 3'd6};
            6'd28:   e = '{bits: 8'h0e, count: 3'd5};
            6'd30:   e = '{bits: 8'h33, count: 3'd6};
            6'd31:   e = '{bits: 8'h29, count: 3'd6};
            6'd32:   e = '{bits: 8'h01, count: 3'd2};
            6'd33:   e = '{bits: 8'h0e, count: 3'd4};
            6'd34:   e = '{bits: 8'h0a, count: 3'd4};
            6'd35:   e = '{bits: 8'h06, count: 3'd3};
            6'd36:   e = '{bits: 8'h01, count: 3'd1};
            6'd37:   e = '{bits: 8'h0b, count: 3'd4};
            6'd38:   e = '{bits: 8'h04, count: 3'd3};
            6'd39:   e = '{bits: 8'h0f, count: 3'd4};
            6'd40:   e = '{bits: 8'h03, count: 3'd2};
            6'd41:   e = '{bits: 8'h01, count: 3'd4};
            6'd42:   e = '{bits: 8'h02, count: 3'd3};
            6'd43:   e = '{bits: 8'h0d, count: 3'd4};
            6'd44:   e = '{bits: 8'h00, count: 3'd2};
            6'd45:   e = '{bits: 8'h02, count: 3'd2};
            6'd46:   e = '{bits: 8'h00, count: 3'd3};
            6'd47:   e = '{bits: 8'h09, count: 3'd4};
            6'd48:   e = '{bits: 8'h04, count: 3'd4};
            6'd49:   e = '{bits: 8'h05, count: 3'd3};
            6'd50:   e = '{bits: 8'h07, count: 3'd3};
            6'd51:   e = '{bits: 8'h00, count: 3'd1};
            6'd52:   e = '{bits: 8'h03, count: 3'd3};
            6'd53:   e = '{bits: 8'h07, count: 3'd4};
            6'd54:   e = '{bits: 8'h01, count: 3'd3};
            6'd55:   e = '{bits: 8'h06, count: 3'd4};
            6'd56:   e = '{bits: 8'h02, count: 3'd4};
            6'd57:   e = '{bits: 8'h0c, count: 3'd4};
            default: e = '{bits: 8'h00, count: 3'd0};
        endcase
        return e;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/tmk_intf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmk_intf
// valid/ready channels for text bytes in and keying segments out
// ----------------------------------------------------------------------------
interface tmk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       first_of_string;
    logic       last_of_string;

    modport source (output valid, char_code, first_of_string, last_of_string, input ready);
    modport sink   (input valid, char_code, first_of_string, last_of_string, output ready);
endinterface

interface tmk_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic       key_on;
    logic [4:0] duration;
    logic       time_unit;
    logic [1:0] power_level;
    logic [7:0] speed_wpm;
    logic       last;

    modport source (output valid, kind, key_on, duration, time_unit, power_level,
                    speed_wpm, last, input ready);
    modport sink   (input valid, kind, key_on, duration, time_unit, power_level,
                    speed_wpm, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/text_to_morse_keyer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// text_to_morse_keyer_top
// ascii text to morse keying segments with power and speed commands
// ----------------------------------------------------------------------------
// Bytes of a text string come in on i_char_if and keying segments leave on
// o_seg_if, one beat per segment, the final segment of a byte flagged by last.
// A byte is taken while the sequencer is idle; the sequencer then walks the
// character's rom entry through one element shift register and writes one
// segment per cycle into the output register whenever that register is free
// or the sink takes its segment, up to 15 segments per byte. i_char_if.ready
// is low while segments are still being produced; it rises once the final
// segment sits in the output register, so the next byte is taken while that
// segment waits. Bytes that yield nothing (speed command digits, ignored
// lowercase, keying at speed zero) leave the sequencer idle. Letters, digits
// and punctuation come from a 58-entry table; '&' keys E, a letter gap, then
// S; space is a word gap; bytes with no code give only a letter gap. Commands:
// 'a'/'b' + digit gives a timed key off/on of digit+1 seconds followed by key
// off, 'z' + two digits sets the speed if it lies between the min and max
// registers, 'u' 'l' 'm' 'h' set the power level.
// Registers over apb: 0x0 start speed (loaded on first_of_string),
// 0x4 min speed, 0x8 max speed, 7 bits each. Write only while idle.
// ----------------------------------------------------------------------------
module text_to_morse_keyer_top
    import tmk_pkg::*;
#(
    parameter int WORD_GAP_DITS   = 9,  // word gap length, 3..15 dits
    parameter int LETTER_GAP_DITS = 3   // letter gap length, 1..7 dits
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // apb configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    // text bytes in, segments out
    tmk_in_if.sink                 i_char_if,
    tmk_out_if.source              o_seg_if
);

    // register file; the user keeps it stable while a byte is sent, unenforced
    t_cfg w_cfg;

    tmk_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // parser, element sequencer and output register
    tmk_seq #(
        .WORD_GAP_DITS   (WORD_GAP_DITS),
        .LETTER_GAP_DITS (LETTER_GAP_DITS)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_char_if (i_char_if),
        .o_seg_if  (o_seg_if)
    );

endmodule
`default_nettype wire

// ===== rtl/tmk_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmk_cfg
// apb register file: start, minimum and maximum speed
// ----------------------------------------------------------------------------
module tmk_cfg
    import tmk_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [1:0] w_index;
    logic       w_write;

    assign w_index = paddr[3:2];
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_write) begin
            unique case (w_index)
                REG_START_SPEED: n_cfg.start_speed_wpm = pwdata[6:0];
                REG_MIN_SPEED:   n_cfg.min_speed_wpm   = pwdata[6:0];
                REG_MAX_SPEED:   n_cfg.max_speed_wpm   = pwdata[6:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            REG_START_SPEED: prdata = {25'd0, r_cfg.start_speed_wpm};
            REG_MIN_SPEED:   prdata = {25'd0, r_cfg.min_speed_wpm};
            REG_MAX_SPEED:   prdata = {25'd0, r_cfg.max_speed_wpm};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{start_speed_wpm: 7'd15, min_speed_wpm: 7'd5, max_speed_wpm: 7'd31};
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tmk_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmk_seq
// byte parser and segment sequencer around one element shift register
// ----------------------------------------------------------------------------
module tmk_seq
    import tmk_pkg::*;
#(
    parameter int WORD_GAP_DITS   = 9,
    parameter int LETTER_GAP_DITS = 3
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    tmk_in_if.sink     i_char_if,
    tmk_out_if.source  o_seg_if
);

    localparam logic [4:0] WordGap   = 5'(WORD_GAP_DITS);
    localparam logic [4:0] LetterGap = 5'(LETTER_GAP_DITS);

    t_state     r_state, n_state;
    t_mode      r_mode,  n_mode;
    logic [7:0] r_tens,  n_tens;
    logic [7:0] r_speed, n_speed;
    logic [1:0] r_power, n_power;
    logic [7:0] r_bits,  n_bits;
    logic [2:0] r_cnt,   n_cnt;
    t_core      r_head,  n_head;
    t_core      r_tail,  n_tail;
    t_seg       r_out,   n_out;
    logic       r_ov,    n_ov;

    logic       w_accept;
    logic       w_can_load;
    logic [7:0] w_c;
    logic [3:0] w_digit;
    t_mode      w_eff_mode;
    logic [7:0] w_eff_speed;
    logic [7:0] w_tens_x10;
    t_elem      w_elem;
    logic [5:0] w_rom_idx;
    logic       w_apply;
    logic [7:0] w_apply_v;

    assign w_c        = i_char_if.char_code;
    assign w_digit    = w_c[3:0];
    assign w_accept   = i_char_if.valid && i_char_if.ready;
    assign w_can_load = !r_ov || o_seg_if.ready;
    assign w_eff_mode = i_char_if.first_of_string ? MODE_NORMAL : r_mode;
    assign w_eff_speed = i_char_if.first_of_string ?
                         {1'b0, i_cfg.start_speed_wpm} : r_speed;
    assign w_tens_x10 = {1'b0, w_digit, 3'b000} + {3'b000, w_digit, 1'b0};
    assign w_rom_idx  = 6'(w_c - C_CH_FIRST);
    assign w_elem     = elem_rom(w_rom_idx);

    assign i_char_if.ready = (r_state == S_IDLE);

    assign o_seg_if.valid       = r_ov;
    assign o_seg_if.kind        = r_out.core.kind;
    assign o_seg_if.key_on      = r_out.core.key_on;
    assign o_seg_if.duration    = r_out.core.duration;
    assign o_seg_if.time_unit   = r_out.core.time_unit;
    assign o_seg_if.power_level = r_out.power_level;
    assign o_seg_if.speed_wpm   = r_out.speed_wpm;
    assign o_seg_if.last        = r_out.last;

    function automatic t_seg mk_seg(input t_core c, input logic [1:0] pw,
                                    input logic [7:0] sp, input logic lst);
        t_seg s;
        s.core        = c;
        s.power_level = pw;
        s.speed_wpm   = sp;
        s.last        = lst;
        return s;
    endfunction

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_tens    = r_tens;
        n_speed   = r_speed;
        n_power   = r_power;
        n_bits    = r_bits;
        n_cnt     = r_cnt;
        n_head    = r_head;
        n_tail    = r_tail;
        n_out     = r_out;
        n_ov      = r_ov;
        w_apply   = 1'b0;
        w_apply_v = 8'd0;

        if (r_ov && o_seg_if.ready) begin
            n_ov = 1'b0;
        end

        if (w_accept) begin
            n_speed = w_eff_speed;
            n_mode  = MODE_NORMAL;
            if (i_char_if.first_of_string) begin
                n_tens = 8'd0;
            end
            unique case (w_eff_mode) inside
                MODE_A, MODE_B: begin
                    n_head  = '{kind: KIND_KEY, key_on: (w_eff_mode == MODE_B),
                                duration: {1'b0, w_digit} + 5'd1, time_unit: UNIT_SECS};
                    n_tail  = '{kind: KIND_KEY, key_on: 1'b0, duration: 5'd0,
                                time_unit: UNIT_SECS};
                    n_state = S_TIMED;
                end
                MODE_Z1: begin
                    n_tens = w_tens_x10;
                    if (i_char_if.last_of_string) begin
                        w_apply   = 1'b1;
                        w_apply_v = w_tens_x10;
                    end else begin
                        n_mode = MODE_Z2;
                    end
                end
                MODE_Z2: begin
                    w_apply   = 1'b1;
                    w_apply_v = r_tens + {4'd0, w_digit};
                end
                default: begin
                    if (w_c >= C_CMD_FIRST && w_c <= C_CMD_LAST) begin
                        n_tail = '{kind: KIND_POWER, key_on: 1'b0, duration: 5'd0,
                                   time_unit: UNIT_DITS};
                        n_head = '{kind: KIND_KEY, key_on: (w_c == C_CMD_B),
                                   duration: 5'd1, time_unit: UNIT_SECS};
                        unique case (w_c)
                            C_CMD_A, C_CMD_B: begin
                                if (i_char_if.last_of_string) begin
                                    n_tail  = '{kind: KIND_KEY, key_on: 1'b0,
                                                duration: 5'd0, time_unit: UNIT_SECS};
                                    n_state = S_TIMED;
                                end else begin
                                    n_mode = (w_c == C_CMD_B) ? MODE_B : MODE_A;
                                end
                            end
                            C_CMD_Z: begin
                                if (i_char_if.last_of_string) begin
                                    w_apply = 1'b1;
                                end else begin
                                    n_mode = MODE_Z1;
                                end
                            end
                            C_CMD_U: begin
                                n_power = PWR_ULTRA_LOW;
                                n_state = S_TAIL;
                            end
                            C_CMD_L: begin
                                n_power = PWR_LOW;
                                n_state = S_TAIL;
                            end
                            C_CMD_M: begin
                                n_power = PWR_MEDIUM;
                                n_state = S_TAIL;
                            end
                            C_CMD_H: begin
                                n_power = PWR_HIGH;
                                n_state = S_TAIL;
                            end
                            default: n_state = S_IDLE;
                        endcase
                    end else if (w_eff_speed != 8'd0) begin
                        // text character, space, or unsupported byte
                        n_tail = '{kind: KIND_KEY, key_on: 1'b0, duration: LetterGap,
                                   time_unit: UNIT_DITS};
                        n_bits = 8'd0;
                        n_cnt  = 3'd0;
                        if (w_c >= C_CH_FIRST && w_c <= C_CH_LAST) begin
                            n_bits = w_elem.bits;
                            n_cnt  = w_elem.count;
                        end
                        if (w_c == C_SPACE) begin
                            n_tail.duration = WordGap;
                            n_state = S_TAIL;
                        end else if (w_c == C_AMP) begin
                            n_state = S_AMP_ON;
                        end else if (n_cnt != 3'd0) begin
                            n_state = S_ON;
                        end else begin
                            n_state = S_TAIL;
                        end
                    end
                end
            endcase

            // shared range check for the speed command
            if (w_apply && w_apply_v >= {1'b0, i_cfg.min_speed_wpm} &&
                w_apply_v <= {1'b0, i_cfg.max_speed_wpm}) begin
                n_speed = w_apply_v;
            end
        end else if (r_state != S_IDLE && w_can_load) begin
            n_ov = 1'b1;
            unique case (r_state)
                S_AMP_ON: begin
                    n_out   = mk_seg('{kind: KIND_KEY, key_on: 1'b1, duration: DIT_LEN,
                                       time_unit: UNIT_DITS}, r_power, r_speed, 1'b0);
                    n_state = S_AMP_GAP;
                end
                S_AMP_GAP: begin
                    n_out   = mk_seg('{kind: KIND_KEY, key_on: 1'b0, duration: LetterGap,
                                       time_unit: UNIT_DITS}, r_power, r_speed, 1'b0);
                    n_state = (r_cnt != 3'd0) ? S_ON : S_TAIL;
                end
                S_ON: begin
                    n_out   = mk_seg('{kind: KIND_KEY, key_on: 1'b1,
                                       duration: r_bits[0] ? DIT_LEN : DAH_LEN,
                                       time_unit: UNIT_DITS}, r_power, r_speed, 1'b0);
                    n_state = S_OFF;
                end
                S_OFF: begin
                    n_out   = mk_seg('{kind: KIND_KEY, key_on: 1'b0, duration: DIT_LEN,
                                       time_unit: UNIT_DITS}, r_power, r_speed, 1'b0);
                    n_bits  = {1'b0, r_bits[7:1]};
                    n_cnt   = r_cnt - 3'd1;
                    n_state = (r_cnt == 3'd1) ? S_TAIL : S_ON;
                end
                S_TIMED: begin
                    n_out   = mk_seg(r_head, r_power, r_speed, 1'b0);
                    n_state = S_TAIL;
                end
                S_TAIL: begin
                    n_out   = mk_seg(r_tail, r_power, r_speed, 1'b1);
                    n_state = S_IDLE;
                end
                default: begin
                    n_ov    = r_ov;
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= MODE_NORMAL;
            r_tens  <= 8'd0;
            r_speed <= 8'd15;
            r_power <= PWR_ULTRA_LOW;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_tens  <= n_tens;
            r_speed <= n_speed;
            r_power <= n_power;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
        r_cnt  <= n_cnt;
        r_head <= n_head;
        r_tail <= n_tail;
        r_out  <= n_out;
    end

`ifndef SYNTHESIS
    a_power_beat_no_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.core.kind) |-> (!r_out.core.key_on && r_out.core.duration == 5'd0))
        else $error("power beat carries keying");

    a_secs_only_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.core.time_unit) |-> !r_out.core.kind)
        else $error("seconds unit on power beat");

    a_dits_need_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_out.core.kind && !r_out.core.time_unit) |-> (r_out.speed_wpm != 8'd0))
        else $error("dit segment sent at zero speed");

    a_elem_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ON || r_state == S_OFF) |-> (r_cnt != 3'd0))
        else $error("element state with empty count");
`endif

endmodule
`default_nettype wire
